### rtl/itoaf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package itoaf_pkg;

	localparam int CMD_W   = 2;
	localparam int VALUE_W = 64;
	localparam int HEX_W   = 32;
	localparam int CHAR_W  = 8;
	localparam int COUNT_W = 5;
	localparam int DIGIT_W = 4;

	localparam int MAX_DIGITS_DEF  = 20;
	localparam int QUEUE_DEPTH_DEF = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_DEC       = 2'd0,
		CMD_HEX_LOWER = 2'd1,
		CMD_HEX_UPPER = 2'd2,
		CMD_POINTER   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		PFX_NONE  = 2'd0,
		PFX_MINUS = 2'd1,
		PFX_HEX   = 2'd2
	} prefix_t;

	// One classified request, as handed from the front to the back
	typedef struct packed {
		prefix_t              prefix;
		logic                 is_hex;
		logic                 upper;
		logic [VALUE_W-1:0]   magnitude;
	} job_t;

endpackage

`default_nettype wire

### rtl/itoaf_front.sv
`timescale 1ns / 1ps
`default_nettype none

module itoaf_front (
	input  logic                           req_valid,
	output logic                           req_ready,
	input  logic [itoaf_pkg::CMD_W-1:0]    command,
	input  logic [itoaf_pkg::VALUE_W-1:0]  value,
	output logic                           push,
	output itoaf_pkg::job_t                push_job,
	input  logic                           full
);
	import itoaf_pkg::*;

	cmd_t cmd;

	assign cmd       = cmd_t'(command);
	assign req_ready = !full;
	assign push      = req_valid && !full;

	// Pick prefix, radix and magnitude for the request
	always_comb begin
		push_job.prefix    = PFX_NONE;
		push_job.is_hex    = 1'b1;
		push_job.upper     = 1'b0;
		push_job.magnitude = value;
		case (cmd)
			CMD_DEC: begin
				push_job.is_hex = 1'b0;
				if (value[VALUE_W-1]) begin
					push_job.prefix    = PFX_MINUS;
					push_job.magnitude = (~value) + {{(VALUE_W-1){1'b0}}, 1'b1};
				end
			end
			CMD_HEX_LOWER: begin
				push_job.magnitude = {{(VALUE_W-HEX_W){1'b0}}, value[HEX_W-1:0]};
			end
			CMD_HEX_UPPER: begin
				push_job.upper     = 1'b1;
				push_job.magnitude = {{(VALUE_W-HEX_W){1'b0}}, value[HEX_W-1:0]};
			end
			CMD_POINTER: begin
				push_job.prefix = PFX_HEX;
			end
			default: begin
				push_job.prefix = PFX_NONE;
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/itoaf_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module itoaf_fifo #(
	parameter int DEPTH = itoaf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  itoaf_pkg::job_t  push_job,
	output logic             full,
	input  logic             pop,
	output itoaf_pkg::job_t  pop_job,
	output logic             empty
);
	import itoaf_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_job = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + CNT_W'(1);
				2'b01: count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

`default_nettype wire

### rtl/itoaf_back.sv
`timescale 1ns / 1ps
`default_nettype none

module itoaf_back #(
	parameter int MAX_DIGITS = itoaf_pkg::MAX_DIGITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           empty,
	output logic                           pop,
	input  itoaf_pkg::job_t                pop_job,
	output logic                           chr_valid,
	input  logic                           chr_ready,
	output logic [itoaf_pkg::CHAR_W-1:0]   character,
	output logic                           last,
	output logic [itoaf_pkg::COUNT_W-1:0]  char_count
);
	import itoaf_pkg::*;

	localparam int BCD_W      = MAX_DIGITS * DIGIT_W;
	localparam int IDX_W      = $clog2(MAX_DIGITS);
	localparam int STEPS      = 2;
	localparam int ITERS      = VALUE_W / STEPS;
	localparam int ITER_W     = $clog2(ITERS);
	localparam int WORD_W     = BCD_W + VALUE_W;

	localparam logic [CHAR_W-1:0] ASC_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] ASC_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] ASC_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] ASC_MINUS   = 8'h2d;
	localparam logic [CHAR_W-1:0] ASC_LOWER_X = 8'h78;
	localparam logic [CHAR_W-1:0] TEN         = 8'd10;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_PREFIX,
		ST_DIGITS
	} state_t;

	state_t              state_q;
	logic [ITER_W-1:0]   iter_q;
	logic [IDX_W-1:0]    idx_q;
	logic                leading_q;
	logic                pfx_second_q;
	logic [COUNT_W-1:0]  run_cnt_q;
	logic                chr_valid_q;
	logic [CHAR_W-1:0]   char_q;
	logic                last_q;
	logic [COUNT_W-1:0]  char_count_q;

	logic [BCD_W-1:0]    digits_q;
	logic [VALUE_W-1:0]  bin_q;
	prefix_t             prefix_q;
	logic                upper_q;

	logic                out_free;
	logic [DIGIT_W-1:0]  cur_digit;
	logic                skip;
	logic                shift_dig;
	logic                emit;
	logic [CHAR_W-1:0]   dig_char;
	logic [WORD_W-1:0]   conv_word;

	// One shift-and-add-3 step over all decimal digits
	function automatic logic [WORD_W-1:0] dabble(input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] r;
		r = w;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (r[VALUE_W + i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
				r[VALUE_W + i*DIGIT_W +: DIGIT_W] =
					r[VALUE_W + i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
			end
		end
		return {r[WORD_W-2:0], 1'b0};
	endfunction

	assign out_free  = !chr_valid_q || chr_ready;
	assign cur_digit = digits_q[BCD_W-1 -: DIGIT_W];
	assign skip      = leading_q && (cur_digit == '0) && (idx_q != '0);
	assign pop       = (state_q == ST_IDLE) && !empty;
	assign shift_dig = (state_q == ST_DIGITS) && out_free;
	assign conv_word = dabble(dabble({digits_q, bin_q}));
	assign emit      = out_free
		&& (((state_q == ST_PREFIX) && (prefix_q == PFX_MINUS || prefix_q == PFX_HEX))
		|| ((state_q == ST_DIGITS) && !skip));

	always_comb begin
		if ({{(CHAR_W-DIGIT_W){1'b0}}, cur_digit} < TEN) begin
			dig_char = ASC_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, cur_digit};
		end else begin
			dig_char = (upper_q ? ASC_UPPER_A : ASC_LOWER_A)
				+ {{(CHAR_W-DIGIT_W){1'b0}}, cur_digit} - TEN;
		end
	end

	// Digit store and job data
	always_ff @(posedge clk) begin
		if (pop) begin
			prefix_q <= pop_job.prefix;
			upper_q  <= pop_job.upper;
			bin_q    <= pop_job.magnitude;
			if (pop_job.is_hex) begin
				digits_q <= {{(BCD_W-VALUE_W){1'b0}}, pop_job.magnitude};
			end else begin
				digits_q <= '0;
			end
		end else if (state_q == ST_CONVERT) begin
			{digits_q, bin_q} <= conv_word;
		end else if (shift_dig) begin
			digits_q <= {digits_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			iter_q       <= '0;
			idx_q        <= '0;
			leading_q    <= 1'b1;
			pfx_second_q <= 1'b0;
			run_cnt_q    <= '0;
			chr_valid_q  <= 1'b0;
			char_q       <= '0;
			last_q       <= 1'b0;
			char_count_q <= '0;
		end else begin
			if (emit) begin
				chr_valid_q <= 1'b1;
			end else if (chr_ready) begin
				chr_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						iter_q       <= '0;
						idx_q        <= IDX_W'(MAX_DIGITS - 1);
						leading_q    <= 1'b1;
						pfx_second_q <= 1'b0;
						run_cnt_q    <= '0;
						state_q      <= pop_job.is_hex ? ST_PREFIX : ST_CONVERT;
					end
				end
				ST_CONVERT: begin
					iter_q <= iter_q + ITER_W'(1);
					if (iter_q == ITER_W'(ITERS - 1)) begin
						state_q <= ST_PREFIX;
					end
				end
				ST_PREFIX: begin
					if (prefix_q == PFX_MINUS || prefix_q == PFX_HEX) begin
						if (out_free) begin
							last_q       <= 1'b0;
							run_cnt_q    <= run_cnt_q + COUNT_W'(1);
							char_count_q <= run_cnt_q + COUNT_W'(1);
							if (prefix_q == PFX_MINUS) begin
								char_q  <= ASC_MINUS;
								state_q <= ST_DIGITS;
							end else if (!pfx_second_q) begin
								char_q       <= ASC_ZERO;
								pfx_second_q <= 1'b1;
							end else begin
								char_q  <= ASC_LOWER_X;
								state_q <= ST_DIGITS;
							end
						end
					end else begin
						state_q <= ST_DIGITS;
					end
				end
				ST_DIGITS: begin
					if (out_free) begin
						if (skip) begin
							idx_q <= idx_q - IDX_W'(1);
						end else begin
							char_q       <= dig_char;
							last_q       <= (idx_q == '0);
							run_cnt_q    <= run_cnt_q + COUNT_W'(1);
							char_count_q <= run_cnt_q + COUNT_W'(1);
							leading_q    <= 1'b0;
							if (idx_q == '0) begin
								state_q <= ST_IDLE;
							end else begin
								idx_q <= idx_q - IDX_W'(1);
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign chr_valid  = chr_valid_q;
	assign character  = char_q;
	assign last       = last_q;
	assign char_count = char_count_q;

endmodule

`default_nettype wire

### rtl/integer_to_ascii_formatter_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake              Payload
// -------   ---------------------  -----------------------------------------
// request   req_valid / req_ready  command[1:0], value[63:0]
// result    chr_valid / chr_ready  character[7:0], last, char_count[4:0]
//
// A decimal request is popped, then converted (two shift-add-3 steps per
// cycle over the 64-bit magnitude), then the prefix state, then one scan
// cycle per digit position while the result channel is free; a hex or pointer
// request skips the conversion. The digit scan sets the tail of every item.
// Reset clears the queue and the converter state; no clearing pass is needed.
// A stall on the result channel freezes the scan; requests keep being taken
// until the queue holds QUEUE_DEPTH of them.

module integer_to_ascii_formatter_unit #(
	parameter int MAX_DIGITS  = itoaf_pkg::MAX_DIGITS_DEF,
	parameter int QUEUE_DEPTH = itoaf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  logic [itoaf_pkg::CMD_W-1:0]    command,
	input  logic [itoaf_pkg::VALUE_W-1:0]  value,
	output logic                           chr_valid,
	input  logic                           chr_ready,
	output logic [itoaf_pkg::CHAR_W-1:0]   character,
	output logic                           last,
	output logic [itoaf_pkg::COUNT_W-1:0]  char_count
);
	import itoaf_pkg::*;

	logic  push;
	logic  full;
	logic  pop;
	logic  empty;
	job_t  push_job;
	job_t  pop_job;

	// Front: classify each request into prefix, radix and magnitude
	itoaf_front u_front (
		.req_valid (req_valid),
		.req_ready (req_ready),
		.command   (command),
		.value     (value),
		.push      (push),
		.push_job  (push_job),
		.full      (full)
	);

	// Queue: hold classified requests so the front need not wait on the scan until the queue is full
	itoaf_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (empty)
	);

	// Back: convert to digits, then emit prefix and digits one per result
	itoaf_back #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (empty),
		.pop        (pop),
		.pop_job    (pop_job),
		.chr_valid  (chr_valid),
		.chr_ready  (chr_ready),
		.character  (character),
		.last       (last),
		.char_count (char_count)
	);

endmodule

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import itoaf_pkg::*;

	// Widest text: a '-' and nineteen decimal digits of the most negative value.
	localparam int DIGIT_LIMIT = MAX_DIGITS_DEF;
	localparam int PHASES = 4;
	localparam int PHASE_REQS = 50;
	localparam int SETTLE_CYCLES = 120;

	localparam byte unsigned CH_MINUS   = "-";
	localparam byte unsigned CH_ZERO    = "0";
	localparam byte unsigned CH_X       = "x";
	localparam byte unsigned CH_LOWER_A = "a";
	localparam byte unsigned CH_UPPER_A = "A";

	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;

	// One request waiting to go out, with the idle gap to leave after it
	// and a flag that holds it back until every pending character is out.
	typedef struct {
		cmd_t        cmd;
		logic [63:0] val;
		int          gap;
		bit          drain;
	} fmt_request_t;

	typedef struct {
		byte unsigned ch;
		bit           last;
		logic [4:0]   count;
	} text_char_t;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	logic [CMD_W-1:0] command = '0;
	logic [VALUE_W-1:0] value = '0;
	logic chr_valid;
	logic chr_ready = 1'b0;
	logic [CHAR_W-1:0] character;
	logic last;
	logic [COUNT_W-1:0] char_count;

	fmt_request_t request_queue[$];
	fmt_request_t next_request;
	text_char_t   text_expect[$];
	text_char_t   seen_char;

	bit req_taken = 1'b0;
	bit chr_taken = 1'b0;
	int req_gap = 0;

	// Receiver stall state: a burst of results shares one mode, either
	// always ready or a random stall drawn anew for each result.
	int rx_left = 0;
	int rx_burst = 0;
	bit rx_calm = 1'b0;

	int mismatches = 0;
	int chars_checked = 0;
	int drains = 0;
	int fmt_seen[4] = '{0, 0, 0, 0};

	integer_to_ascii_formatter_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.command    (command),
		.value      (value),
		.chr_valid  (chr_valid),
		.chr_ready  (chr_ready),
		.character  (character),
		.last       (last),
		.char_count (char_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("[%0t] check failed: %s", $time, what);
	endtask

	// Work out the full text of one request and append its characters,
	// with last mark and running count, to the expected text.
	function automatic void predict_text(input cmd_t cmd, input logic [63:0] v);
		logic [63:0] mag;
		logic [63:0] radix;
		logic [3:0] digits[$];
		byte unsigned text[$];
		bit upper;
		upper = (cmd == CMD_HEX_UPPER);
		radix = (cmd == CMD_DEC) ? 64'd10 : 64'd16;
		case (cmd)
			CMD_DEC: begin
				// Negate modulo 2^64, so the most negative value keeps its magnitude.
				if (v[63]) begin
					text.push_back(CH_MINUS);
					mag = ~v + 64'd1;
				end else begin
					mag = v;
				end
			end
			CMD_POINTER: begin
				text.push_back(CH_ZERO);
				text.push_back(CH_X);
				mag = v;
			end
			default: begin
				// Hex formats see only the low word.
				mag = {32'd0, v[31:0]};
			end
		endcase
		// Zero still yields a single digit.
		do begin
			digits.push_front(4'(mag % radix));
			mag = mag / radix;
		end while (mag != 64'd0 && digits.size() < DIGIT_LIMIT);
		foreach (digits[i]) begin
			text.push_back(digits[i] < 4'd10 ? CH_ZERO + digits[i] :
				(upper ? CH_UPPER_A : CH_LOWER_A) + digits[i] - 8'd10);
		end
		foreach (text[i]) begin
			text_expect.push_back('{text[i], i == text.size() - 1, 5'(i + 1)});
		end
	endfunction

	function automatic void queue_request(input cmd_t cmd, input logic [63:0] v,
			input int gap, input bit drain);
		request_queue.push_back('{cmd, v, gap, drain});
	endfunction

	// Spread values over every digit length, both signs and the edges.
	function automatic logic [63:0] random_value();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: v = v;
			1: v = 64'($urandom_range(0, 20));
			2: v = v >> $urandom_range(0, 63);
			3: v = -(v >> $urandom_range(1, 63));
			4: begin
				case ($urandom_range(0, 3))
					0: v = '0;
					1: v = ALL_ONES;
					2: v = MOST_NEG;
					default: v = MOST_POS;
				endcase
			end
			default: v = {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0, $urandom};
		endcase
		return v;
	endfunction

	// Request driver: hold a request until taken, then idle for its gap,
	// then launch the next one from the queue.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (req_valid && !req_taken) begin
			// hold: valid and payload stay put until the handshake
		end else if (req_gap != 0) begin
			req_valid <= 1'b0;
			req_gap <= req_gap - 1;
		end else if (request_queue.size() != 0 &&
				!(request_queue[0].drain && text_expect.size() != 0)) begin
			next_request = request_queue.pop_front();
			if (next_request.drain) begin
				drains++;
			end
			command <= next_request.cmd;
			value <= next_request.val;
			req_valid <= 1'b1;
			req_gap <= next_request.gap;
		end else begin
			req_valid <= 1'b0;
		end
	end

	// Result receiver: after each taken character draw a stall, and now and
	// then switch between stalling and calm stretches.
	always @(negedge clk) begin
		if (!arst_n) begin
			chr_ready <= 1'b0;
		end else begin
			if (chr_taken) begin
				rx_left = rx_calm ? 0 : $urandom_range(0, 8);
				if (rx_burst == 0) begin
					rx_burst = $urandom_range(10, 60);
					rx_calm = $urandom_range(0, 1);
				end else begin
					rx_burst = rx_burst - 1;
				end
			end else if (rx_left != 0) begin
				rx_left = rx_left - 1;
			end
			chr_ready <= (rx_left == 0);
		end
	end

	// Monitor: on each rising edge note both handshakes, predict the text of
	// a taken request, and check a taken character against the oldest one due.
	always @(posedge clk) begin
		req_taken <= arst_n && req_valid && req_ready;
		chr_taken <= arst_n && chr_valid && chr_ready;
		if (arst_n && req_valid && req_ready) begin
			predict_text(cmd_t'(command), value);
			fmt_seen[command]++;
		end
		if (arst_n && chr_valid && chr_ready) begin
			chars_checked++;
			if (text_expect.size() == 0) begin
				report_mismatch($sformatf("character 0x%02h with nothing pending", character));
			end else begin
				seen_char = text_expect.pop_front();
				if (character !== seen_char.ch) begin
					report_mismatch($sformatf("character 0x%02h, want 0x%02h",
						character, seen_char.ch));
				end
				if (last !== seen_char.last) begin
					report_mismatch($sformatf("last %b, want %b on character 0x%02h",
						last, seen_char.last, seen_char.ch));
				end
				if (char_count !== seen_char.count) begin
					report_mismatch($sformatf("char_count %0d, want %0d",
						char_count, seen_char.count));
				end
			end
		end
	end

	initial begin
		// Directed: zero and sign edges in decimal, the longest text, hex with
		// junk in the high word, both letter cases, and pointer edges.
		queue_request(CMD_DEC, 64'd0, $urandom_range(0, 8), 1'b0);
		queue_request(CMD_DEC, 64'd1, $urandom_range(0, 8), 1'b0);
		queue_request(CMD_DEC, ALL_ONES, $urandom_range(0, 8), 1'b0);
		queue_request(CMD_DEC, MOST_POS, $urandom_range(0, 8), 1'b0);
		queue_request(CMD_DEC, MOST_NEG, $urandom_range(0, 8), 1'b0);
		queue_request(CMD_DEC, 64'd10, $urandom_range(0, 8), 1'b0);
		queue_request(CMD_DEC, 64'd9, $urandom_range(0, 8), 1'b0);
		queue_request(CMD_HEX_LOWER, 64'd0, $urandom_range(0, 8), 1'b0);
		queue_request(CMD_HEX_LOWER, 64'h0000_0000_FFFF_FFFF, $urandom_range(0, 8), 1'b0);
		queue_request(CMD_HEX_LOWER, 64'hFFFF_FFFF_0000_0000, $urandom_range(0, 8), 1'b0);
		queue_request(CMD_HEX_LOWER, 64'h1234_5678_9ABC_DEF0, $urandom_range(0, 8), 1'b0);
		queue_request(CMD_HEX_UPPER, 64'hDEAD_BEEF_ABCD_EF01, $urandom_range(0, 8), 1'b0);
		queue_request(CMD_HEX_UPPER, ALL_ONES, $urandom_range(0, 8), 1'b0);
		queue_request(CMD_HEX_UPPER, 64'hFFFF_FFFF_0000_0000, $urandom_range(0, 8), 1'b0);
		queue_request(CMD_HEX_UPPER, 64'd15, $urandom_range(0, 8), 1'b0);
		queue_request(CMD_POINTER, 64'd0, $urandom_range(0, 8), 1'b0);
		queue_request(CMD_POINTER, 64'd1, $urandom_range(0, 8), 1'b0);
		queue_request(CMD_POINTER, ALL_ONES, $urandom_range(0, 8), 1'b0);
		queue_request(CMD_POINTER, MOST_NEG, $urandom_range(0, 8), 1'b0);
		queue_request(CMD_POINTER, 64'h0123_4567_89AB_CDEF, 0, 1'b0);

		// Random phases; the first request of each waits for the text to drain.
		// The second phase runs back to back, the others idle at random.
		for (int p = 0; p < PHASES; p++) begin
			for (int i = 0; i < PHASE_REQS; i++) begin
				queue_request(cmd_t'($urandom_range(0, 3)), random_value(),
					(p == 1) ? 0 : $urandom_range(0, 8), i == 0);
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait for every request to go out, then for the text to drain, then
		// watch a while longer for any stray character.
		while (request_queue.size() != 0 || req_valid) @(posedge clk);
		while (text_expect.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Formatted %0d decimal, %0d lower hex, %0d upper hex, %0d pointer requests;",
			fmt_seen[0], fmt_seen[1], fmt_seen[2], fmt_seen[3]);
		$display("%0d characters checked, %0d drain pauses, %0d check failures.",
			chars_checked, drains, mismatches);
		if (mismatches == 0) begin
			$display("integer_to_ascii_formatter_unit: match");
		end else begin
			$display("integer_to_ascii_formatter_unit: mismatch");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("Run did not finish in time.");
		$display("integer_to_ascii_formatter_unit: mismatch");
		$finish;
	end

endmodule

### files.f
rtl/itoaf_pkg.sv
rtl/itoaf_front.sv
rtl/itoaf_fifo.sv
rtl/itoaf_back.sv
rtl/integer_to_ascii_formatter_unit.sv
sim/testbench.sv
